@@ src/kct48_pkg.sv @@
// ----------------------------------------------------------------------------
// kct48_pkg
// Shared codes and the command and status bundles that join the controller
// and the datapath of the keyed child table.
// ----------------------------------------------------------------------------
package kct48_pkg;

  localparam int CNT_W = 6;

  localparam logic [2:0] REQ_LOOKUP = 3'd0;
  localparam logic [2:0] REQ_INSERT = 3'd1;
  localparam logic [2:0] REQ_CHANGE = 3'd2;
  localparam logic [2:0] REQ_REMOVE = 3'd3;
  localparam logic [2:0] REQ_RANGE  = 3'd4;
  localparam logic [2:0] REQ_ANY    = 3'd5;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_FULL    = 3'd1;
  localparam logic [2:0] ST_ABSENT  = 3'd2;
  localparam logic [2:0] ST_PRESENT = 3'd3;
  localparam logic [2:0] ST_ZERO    = 3'd4;

  localparam logic [1:0] KS_REQ   = 2'd0;
  localparam logic [1:0] KS_FETCH = 2'd1;
  localparam logic [1:0] KS_ZERO  = 2'd2;

  localparam logic [1:0] CS_ZERO = 2'd0;
  localparam logic [1:0] CS_VAL  = 2'd1;
  localparam logic [1:0] CS_SLOT = 2'd2;

  localparam logic [CNT_W-1:0] MAX_RESULTS   = 6'd48;
  localparam logic [CNT_W-1:0] UNDERFULL_RST = 6'd12;

  typedef struct packed {
    logic       load_in;
    logic       stage;
    logic       found;
    logic [2:0] status;
    logic [1:0] ksel;
    logic [1:0] csel;
    logic       emit;
    logic       last;
    logic       pos_load_cnt;
    logic       pos_clear;
    logic       pos_inc;
    logic       ins_write;
    logic       chg_write;
    logic       rem_write;
    logic       idx_rd;
    logic       slot_rd;
    logic       scan_init_range;
    logic       scan_init_any;
    logic       take_hit;
    logic       take_leaf;
    logic       take_last;
    logic       scan_next;
    logic       cnt_inc;
  } cmd_t;

  typedef struct packed {
    logic [2:0] req;
    logic       key_bad;
    logic       present;
    logic       val_zero;
    logic       full;
    logic       cnt_free;
    logic       pos_free;
    logic       pos_end;
    logic       scan_end;
    logic       win_hit;
    logic       leaf_hit;
    logic       have;
    logic       stage_found;
    logic       cnt_last;
    logic       out_free;
  } sts_t;

endpackage

@@ src/kct48_ram.sv @@
// ----------------------------------------------------------------------------
// kct48_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module kct48_ram #(
  parameter int W = 8,
  parameter int D = 16,
  localparam int AW = $clog2(D)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);

  logic [W-1:0] mem_r [D];
  logic [W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ src/kct48_ctrl.sv @@
// ----------------------------------------------------------------------------
// kct48_ctrl
// Request sequencer: decodes each request, steps the memory reads, the free
// slot search and the key scans, and times the result transfers.
// ----------------------------------------------------------------------------
module kct48_ctrl import kct48_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DEC   = 4'd1;
  localparam logic [3:0] S_FREE  = 4'd2;
  localparam logic [3:0] S_WR    = 4'd3;
  localparam logic [3:0] S_RDX   = 4'd4;
  localparam logic [3:0] S_RDI   = 4'd5;
  localparam logic [3:0] S_RDS   = 4'd6;
  localparam logic [3:0] S_SCAN  = 4'd7;
  localparam logic [3:0] S_ASCAN = 4'd8;
  localparam logic [3:0] S_SPUSH = 4'd9;
  localparam logic [3:0] S_SFIN  = 4'd10;
  localparam logic [3:0] S_RES   = 4'd11;

  logic [3:0] state_r;
  logic [3:0] state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = S_DEC;
        end
      end
      S_DEC: begin
        cmd.ksel = KS_REQ;
        cmd.csel = CS_ZERO;
        case (sts.req)
          REQ_LOOKUP, REQ_REMOVE: begin
            if (sts.present) begin
              state_nxt = S_RDX;
            end else begin
              cmd.stage  = 1'b1;
              cmd.status = ST_ABSENT;
              state_nxt  = S_RES;
            end
          end
          REQ_INSERT: begin
            if (sts.val_zero || sts.key_bad || sts.present || sts.full) begin
              cmd.stage = 1'b1;
              state_nxt = S_RES;
              if (sts.val_zero) begin
                cmd.status = ST_ZERO;
              end else if (sts.key_bad) begin
                cmd.status = ST_ABSENT;
              end else if (sts.present) begin
                cmd.status = ST_PRESENT;
              end else begin
                cmd.status = ST_FULL;
              end
            end else if (sts.cnt_free) begin
              cmd.pos_load_cnt = 1'b1;
              state_nxt        = S_WR;
            end else begin
              cmd.pos_clear = 1'b1;
              state_nxt     = S_FREE;
            end
          end
          REQ_CHANGE: begin
            if (sts.val_zero || !sts.present) begin
              cmd.stage  = 1'b1;
              cmd.status = sts.val_zero ? ST_ZERO : ST_ABSENT;
              state_nxt  = S_RES;
            end else begin
              state_nxt = S_RDX;
            end
          end
          REQ_RANGE: begin
            cmd.scan_init_range = 1'b1;
            cmd.stage           = 1'b1;
            cmd.status          = ST_ABSENT;
            state_nxt           = S_SCAN;
          end
          REQ_ANY: begin
            cmd.scan_init_any = 1'b1;
            state_nxt         = S_ASCAN;
          end
          default: begin
            cmd.stage  = 1'b1;
            cmd.status = ST_OK;
            state_nxt  = S_RES;
          end
        endcase
      end
      S_FREE: begin
        if (sts.pos_free) begin
          state_nxt = S_WR;
        end else if (sts.pos_end) begin
          cmd.stage  = 1'b1;
          cmd.status = ST_FULL;
          cmd.ksel   = KS_REQ;
          cmd.csel   = CS_ZERO;
          state_nxt  = S_RES;
        end else begin
          cmd.pos_inc = 1'b1;
        end
      end
      S_WR: begin
        cmd.ins_write = 1'b1;
        cmd.stage     = 1'b1;
        cmd.status    = ST_OK;
        cmd.ksel      = KS_REQ;
        cmd.csel      = CS_VAL;
        state_nxt     = S_RES;
      end
      S_RDX: begin
        cmd.idx_rd = 1'b1;
        state_nxt  = S_RDI;
      end
      S_RDI: begin
        if (sts.req == REQ_CHANGE) begin
          cmd.chg_write = 1'b1;
          cmd.stage     = 1'b1;
          cmd.found     = 1'b1;
          cmd.status    = ST_OK;
          cmd.ksel      = KS_REQ;
          cmd.csel      = CS_VAL;
          state_nxt     = S_RES;
        end else begin
          cmd.slot_rd = 1'b1;
          state_nxt   = (sts.req == REQ_RANGE) ? S_SPUSH : S_RDS;
        end
      end
      S_RDS: begin
        cmd.rem_write = (sts.req == REQ_REMOVE);
        cmd.stage     = 1'b1;
        cmd.found     = 1'b1;
        cmd.status    = ST_OK;
        cmd.ksel      = KS_FETCH;
        cmd.csel      = CS_SLOT;
        state_nxt     = S_RES;
      end
      S_SCAN: begin
        if (sts.scan_end) begin
          state_nxt = S_SFIN;
        end else if (sts.win_hit) begin
          cmd.take_hit = 1'b1;
          state_nxt    = S_RDX;
        end else begin
          cmd.scan_next = 1'b1;
        end
      end
      S_ASCAN: begin
        if (sts.scan_end) begin
          if (sts.have) begin
            cmd.take_last = 1'b1;
            state_nxt     = S_RDX;
          end else begin
            cmd.stage  = 1'b1;
            cmd.status = ST_ABSENT;
            cmd.ksel   = KS_ZERO;
            cmd.csel   = CS_ZERO;
            state_nxt  = S_RES;
          end
        end else if (sts.leaf_hit) begin
          cmd.take_leaf = 1'b1;
          state_nxt     = S_RDX;
        end else begin
          cmd.scan_next = 1'b1;
        end
      end
      S_SPUSH: begin
        if (!sts.stage_found || sts.out_free) begin
          cmd.emit    = sts.stage_found;
          cmd.stage   = 1'b1;
          cmd.found   = 1'b1;
          cmd.status  = ST_OK;
          cmd.ksel    = KS_FETCH;
          cmd.csel    = CS_SLOT;
          cmd.cnt_inc = 1'b1;
          state_nxt   = sts.cnt_last ? S_SFIN : S_SCAN;
        end
      end
      S_SFIN, S_RES: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          cmd.last  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

@@ src/kct48_dp.sv @@
// ----------------------------------------------------------------------------
// kct48_dp
// Datapath: request registers, key presence and leaf flags, slot occupancy,
// the key index and slot memories, the group scanner and the result register.
// ----------------------------------------------------------------------------
module kct48_dp import kct48_pkg::*; #(
  parameter int SLOTS       = 48,
  parameter int KEY_SPACE   = 256,
  parameter int VALUE_WIDTH = 64
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  cmd_t                   cmd,
  output sts_t                   sts,
  input  logic [2:0]             in_req_type,
  input  logic [7:0]             in_key,
  input  logic [7:0]             in_range_end,
  input  logic [VALUE_WIDTH-1:0] in_child_value,
  input  logic [CNT_W-1:0]       level,
  input  logic                   out_ready,
  output logic                   out_valid,
  output logic                   out_found,
  output logic [7:0]             out_key_out,
  output logic [VALUE_WIDTH-1:0] out_child_out,
  output logic [2:0]             out_status,
  output logic [CNT_W-1:0]       out_entries,
  output logic                   out_full_res,
  output logic                   out_underfull,
  output logic                   out_last
);

  localparam int SW = $clog2(SLOTS);
  localparam int KW = $clog2(KEY_SPACE);
  localparam int KP = 1 << KW;

  logic [2:0]             req_r;
  logic [7:0]             key_r;
  logic [7:0]             end_r;
  logic [VALUE_WIDTH-1:0] val_r;
  logic [7:0]             fkey_r;
  logic [8:0]             cur_r;
  logic [7:0]             lastp_r;
  logic                   have_r;
  logic [SW-1:0]          pos_r;
  logic [CNT_W-1:0]       rcnt_r;
  logic [CNT_W-1:0]       cnt_r;
  logic [KEY_SPACE-1:0]   pres_r;
  logic [KEY_SPACE-1:0]   leafk_r;
  logic [SLOTS-1:0]       occ_r;

  logic                   stg_found_r;
  logic [7:0]             stg_key_r;
  logic [VALUE_WIDTH-1:0] stg_child_r;
  logic [2:0]             stg_status_r;

  logic                   out_valid_r;
  logic                   out_found_r;
  logic [7:0]             out_key_r;
  logic [VALUE_WIDTH-1:0] out_child_r;
  logic [2:0]             out_status_r;
  logic [CNT_W-1:0]       out_entries_r;
  logic                   out_full_r;
  logic                   out_underfull_r;
  logic                   out_last_r;

  logic [KP-1:0]          pres_pad;
  logic [KP-1:0]          leaf_pad;
  logic [KW-1:0]          grp_base;
  logic [7:0]             pg;
  logic [7:0]             lg;
  logic [7:0]             win;
  logic [7:0]             lwin;
  logic                   win_hit;
  logic                   leaf_hit;
  logic [2:0]             hit_b;
  logic [2:0]             leaf_b;
  logic [2:0]             top_b;
  logic [7:0]             hit_key;
  logic                   key_bad;
  logic                   out_free;

  logic [SW-1:0]          idx_rdata;
  logic [VALUE_WIDTH-1:0] slot_rdata;
  logic                   slot_we;
  logic [SW-1:0]          slot_waddr;
  logic [VALUE_WIDTH-1:0] slot_wdata;

  kct48_ram #(.W(SW), .D(KEY_SPACE)) u_idx_ram (
    .clk   (clk),
    .we    (cmd.ins_write),
    .waddr (fkey_r[KW-1:0]),
    .wdata (pos_r),
    .re    (cmd.idx_rd),
    .raddr (fkey_r[KW-1:0]),
    .rdata (idx_rdata)
  );

  always_comb begin
    slot_we    = cmd.ins_write || cmd.chg_write || cmd.rem_write;
    slot_waddr = cmd.ins_write ? pos_r : idx_rdata;
    slot_wdata = cmd.rem_write ? '0 : val_r;
  end

  kct48_ram #(.W(VALUE_WIDTH), .D(SLOTS)) u_slot_ram (
    .clk   (clk),
    .we    (slot_we),
    .waddr (slot_waddr),
    .wdata (slot_wdata),
    .re    (cmd.slot_rd),
    .raddr (idx_rdata),
    .rdata (slot_rdata)
  );

  always_comb begin
    pres_pad                  = '0;
    leaf_pad                  = '0;
    pres_pad[KEY_SPACE-1:0]   = pres_r;
    leaf_pad[KEY_SPACE-1:0]   = leafk_r;
  end

  assign grp_base = {cur_r[KW-1:3], 3'b000};
  assign pg       = pres_pad[grp_base +: 8];
  assign lg       = leaf_pad[grp_base +: 8];

  always_comb begin
    win      = '0;
    win_hit  = 1'b0;
    leaf_hit = 1'b0;
    hit_b    = '0;
    leaf_b   = '0;
    top_b    = '0;
    for (int b = 0; b < 8; b++) begin
      win[b] = pg[b] && (3'(b) >= cur_r[2:0]) &&
               ({cur_r[8:3], 3'(b)} <= {1'b0, end_r});
    end
    lwin = win & lg;
    for (int b = 7; b >= 0; b--) begin
      if (win[b]) begin
        win_hit = 1'b1;
        hit_b   = 3'(b);
      end
      if (lwin[b]) begin
        leaf_hit = 1'b1;
        leaf_b   = 3'(b);
      end
    end
    for (int b = 0; b < 8; b++) begin
      if (win[b]) begin
        top_b = 3'(b);
      end
    end
  end

  assign hit_key  = {cur_r[7:3], hit_b};
  assign key_bad  = ({1'b0, key_r} >= 9'(KEY_SPACE));
  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    sts             = '0;
    sts.req         = req_r;
    sts.key_bad     = key_bad;
    sts.present     = !key_bad && pres_pad[key_r[KW-1:0]];
    sts.val_zero    = (val_r == '0);
    sts.full        = (cnt_r >= CNT_W'(SLOTS));
    sts.cnt_free    = !occ_r[cnt_r[SW-1:0]];
    sts.pos_free    = !occ_r[pos_r];
    sts.pos_end     = (pos_r == SW'(SLOTS - 1));
    sts.scan_end    = (cur_r > {1'b0, end_r}) || (cur_r >= 9'(KEY_SPACE));
    sts.win_hit     = win_hit;
    sts.leaf_hit    = leaf_hit;
    sts.have        = have_r;
    sts.stage_found = stg_found_r;
    sts.cnt_last    = (rcnt_r == MAX_RESULTS - 6'd1);
    sts.out_free    = out_free;
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      req_r  <= in_req_type;
      key_r  <= in_key;
      end_r  <= in_range_end;
      val_r  <= in_child_value;
      fkey_r <= in_key;
    end
    if (cmd.scan_init_range) begin
      cur_r <= {1'b0, key_r};
    end
    if (cmd.scan_init_any) begin
      cur_r <= '0;
      end_r <= 8'(KEY_SPACE - 1);
    end
    if (cmd.take_hit) begin
      fkey_r <= hit_key;
      cur_r  <= {1'b0, hit_key} + 9'd1;
    end
    if (cmd.take_leaf) begin
      fkey_r <= {cur_r[7:3], leaf_b};
    end
    if (cmd.take_last) begin
      fkey_r <= lastp_r;
    end
    if (cmd.scan_next) begin
      cur_r <= {cur_r[8:3] + 6'd1, 3'b000};
      if (win_hit) begin
        lastp_r <= {cur_r[7:3], top_b};
      end
    end
    if (cmd.pos_load_cnt) begin
      pos_r <= cnt_r[SW-1:0];
    end else if (cmd.pos_clear) begin
      pos_r <= '0;
    end else if (cmd.pos_inc) begin
      pos_r <= pos_r + SW'(1);
    end
    if (cmd.ins_write || cmd.chg_write) begin
      leafk_r[fkey_r[KW-1:0]] <= val_r[VALUE_WIDTH-1];
    end
    if (cmd.stage) begin
      stg_found_r  <= cmd.found;
      stg_status_r <= cmd.status;
      case (cmd.ksel)
        KS_REQ:   stg_key_r <= key_r;
        KS_FETCH: stg_key_r <= fkey_r;
        default:  stg_key_r <= '0;
      endcase
      case (cmd.csel)
        CS_VAL:  stg_child_r <= val_r;
        CS_SLOT: stg_child_r <= slot_rdata;
        default: stg_child_r <= '0;
      endcase
    end
    if (cmd.emit) begin
      out_found_r     <= stg_found_r;
      out_key_r       <= stg_key_r;
      out_child_r     <= stg_child_r;
      out_status_r    <= stg_status_r;
      out_entries_r   <= cnt_r;
      out_full_r      <= (cnt_r == CNT_W'(SLOTS));
      out_underfull_r <= (cnt_r == level);
      out_last_r      <= cmd.last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      pres_r      <= '0;
      occ_r       <= '0;
      have_r      <= 1'b0;
      rcnt_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.load_in) begin
        rcnt_r <= '0;
      end else if (cmd.cnt_inc) begin
        rcnt_r <= rcnt_r + 6'd1;
      end
      if (cmd.scan_init_any) begin
        have_r <= 1'b0;
      end else if (cmd.scan_next && win_hit) begin
        have_r <= 1'b1;
      end
      if (cmd.ins_write) begin
        pres_r[fkey_r[KW-1:0]] <= 1'b1;
        occ_r[pos_r]           <= 1'b1;
        cnt_r                  <= cnt_r + 6'd1;
      end else if (cmd.rem_write) begin
        pres_r[fkey_r[KW-1:0]] <= 1'b0;
        occ_r[idx_rdata]       <= 1'b0;
        cnt_r                  <= cnt_r - 6'd1;
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid     = out_valid_r;
  assign out_found     = out_found_r;
  assign out_key_out   = out_key_r;
  assign out_child_out = out_child_r;
  assign out_status    = out_status_r;
  assign out_entries   = out_entries_r;
  assign out_full_res  = out_full_r;
  assign out_underfull = out_underfull_r;
  assign out_last      = out_last_r;

endmodule

@@ src/keyed_child_table_48.sv @@
// ----------------------------------------------------------------------------
// keyed_child_table_48
// Node of up to SLOTS children addressed by a key byte, with lookup, insert,
// change, remove, key range scan and any-child requests.
// ----------------------------------------------------------------------------
// Requests arrive on the in_ valid/ready channel, one at a time; in_ready is
// high only while no request is in progress. Results leave on the out_
// channel from an output register; a range scan gives one transfer per
// present key in ascending order, or one miss transfer if there is none,
// with out_last set on the final one; every other request gives exactly one.
// Misuse and unused requests are answered from the decode step. Insert
// writes the slot at the entry count, or searches the slots from slot 0
// when that slot is taken; change reads the key index and then writes the
// slot; lookup and remove read the key index and then the slot memory. A
// scan tests a group of 8 keys per step and reads both memories for each
// key reported; any-child walks up to KEY_SPACE/8 groups and then fetches
// one child as a lookup does. The next request is accepted only after the
// final result is loaded. Each memory has a single read port.
// On a stall the held result stays; a scan waits once a next key is fetched.
// Reset empties the table and sets underfull_level to 12; the memories need
// no clearing pass. underfull_level is written over the APB-style port.
// ----------------------------------------------------------------------------
module keyed_child_table_48 import kct48_pkg::*; #(
  parameter int SLOTS       = 48,
  parameter int KEY_SPACE   = 256,
  parameter int VALUE_WIDTH = 64
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [2:0]             in_req_type,
  input  logic [7:0]             in_key,
  input  logic [7:0]             in_range_end,
  input  logic [VALUE_WIDTH-1:0] in_child_value,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic                   out_found,
  output logic [7:0]             out_key_out,
  output logic [VALUE_WIDTH-1:0] out_child_out,
  output logic [2:0]             out_status,
  output logic [CNT_W-1:0]       out_entries,
  output logic                   out_full_res,
  output logic                   out_underfull,
  output logic                   out_last,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [1:0]             paddr,
  input  logic [31:0]            pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);

  cmd_t             cmd;
  sts_t             sts;
  logic [CNT_W-1:0] level_r;

  assign pready = 1'b1;
  assign prdata = {26'd0, level_r} & {32{paddr == 2'd0 || paddr != 2'd0}};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r <= UNDERFULL_RST;
    end else if (psel && penable && pwrite) begin
      level_r <= pwdata[CNT_W-1:0];
    end
  end

  kct48_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  kct48_dp #(
    .SLOTS       (SLOTS),
    .KEY_SPACE   (KEY_SPACE),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_req_type    (in_req_type),
    .in_key         (in_key),
    .in_range_end   (in_range_end),
    .in_child_value (in_child_value),
    .level          (level_r),
    .out_ready      (out_ready),
    .out_valid      (out_valid),
    .out_found      (out_found),
    .out_key_out    (out_key_out),
    .out_child_out  (out_child_out),
    .out_status     (out_status),
    .out_entries    (out_entries),
    .out_full_res   (out_full_res),
    .out_underfull  (out_underfull),
    .out_last       (out_last)
  );

endmodule

@@ src/kct48_chk.sv @@
// ----------------------------------------------------------------------------
// kct48_chk
// Port-level checks on the result channel of the keyed child table.
// ----------------------------------------------------------------------------
module kct48_chk import kct48_pkg::*; #(
  parameter int SLOTS       = 48,
  parameter int VALUE_WIDTH = 64
) (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   out_valid,
  input logic                   out_ready,
  input logic                   out_found,
  input logic [7:0]             out_key_out,
  input logic [VALUE_WIDTH-1:0] out_child_out,
  input logic [2:0]             out_status,
  input logic [CNT_W-1:0]       out_entries,
  input logic                   out_full_res,
  input logic                   out_underfull,
  input logic                   out_last
);

  a_full_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_full_res == (out_entries == CNT_W'(SLOTS))))
    else $error("full flag disagrees with entry count");

  a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_found) |-> (out_status == ST_OK && out_child_out != '0))
    else $error("found result without ok status or with a null child");

  a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_FULL) |-> out_full_res)
    else $error("table full status while slots are free");

  a_miss_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_found) |-> out_last)
    else $error("miss result not marked last");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_found) &&
      $stable(out_key_out) && $stable(out_child_out) && $stable(out_status) &&
      $stable(out_entries) && $stable(out_underfull) && $stable(out_last)))
    else $error("stalled result transfer changed");

endmodule

bind keyed_child_table_48 kct48_chk #(
  .SLOTS       (SLOTS),
  .VALUE_WIDTH (VALUE_WIDTH)
) u_kct48_chk (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_found     (out_found),
  .out_key_out   (out_key_out),
  .out_child_out (out_child_out),
  .out_status    (out_status),
  .out_entries   (out_entries),
  .out_full_res  (out_full_res),
  .out_underfull (out_underfull),
  .out_last      (out_last)
);
